FILE: design/etfi_pkg.sv
// ----------------------------------------------------------------------------
// etfi_pkg - shared types and helpers for the escape-time fractal iterator
// Constants, register indexes, slot and config structs, saturation helpers.
// ----------------------------------------------------------------------------
package etfi_pkg;

    localparam int IMAGE_WIDTH   = 1024;
    localparam int IMAGE_HEIGHT  = 1024;
    localparam int FRACTION_BITS = 28;

    // image sizes are powers of two: mapping divides by a shift
    localparam int WIDTH_SHIFT  = $clog2(IMAGE_WIDTH);
    localparam int HEIGHT_SHIFT = $clog2(IMAGE_HEIGHT);

    // bias added to negative products so the shift truncates toward zero
    localparam int IMAGE_WIDTH_M1  = IMAGE_WIDTH - 1;
    localparam int IMAGE_HEIGHT_M1 = IMAGE_HEIGHT - 1;

    // ring of iteration cells; power of two so tags wrap cleanly
    localparam int NUM_CELLS = 4;
    localparam int TAG_W     = $clog2(NUM_CELLS);

    // escape threshold: 4 scaled by 2^(2*FRACTION_BITS)
    localparam logic [63:0] ESC_LIMIT = 64'd4 << (2 * FRACTION_BITS);

    localparam logic [2:0] REG_FRACTAL_MODE   = 3'd0;
    localparam logic [2:0] REG_MAX_ITERATIONS = 3'd1;
    localparam logic [2:0] REG_X_MIN          = 3'd2;
    localparam logic [2:0] REG_X_MAX          = 3'd3;
    localparam logic [2:0] REG_Y_MIN          = 3'd4;
    localparam logic [2:0] REG_Y_MAX          = 3'd5;
    localparam logic [2:0] REG_JULIA_RE       = 3'd6;
    localparam logic [2:0] REG_JULIA_IM       = 3'd7;

    localparam logic [1:0] MODE_MANDELBROT = 2'd0;
    localparam logic [1:0] MODE_JULIA      = 2'd1;
    localparam logic [1:0] MODE_SHIP       = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [10:0]        max_iter;
    } step_cfg_t;

    typedef struct packed {
        logic signed [31:0] x_min;
        logic signed [31:0] x_max;
        logic signed [31:0] y_min;
        logic signed [31:0] y_max;
    } window_t;

    // one pixel in flight; n is steps taken, and the final count once done
    typedef struct packed {
        logic               valid;
        logic               done;
        logic [TAG_W-1:0]   tag;
        logic [10:0]        n;
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
    } slot_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] abs_sat(input logic signed [31:0] a);
        logic signed [31:0] r;
        if (a == 32'sh80000000)
            r = 32'sh7fffffff;
        else if (a < 0)
            r = -a;
        else
            r = a;
        return r;
    endfunction

endpackage

FILE: design/etfi_map.sv
// ----------------------------------------------------------------------------
// etfi_map - pixel to complex-plane mapping
// Two stages: span times pixel, then divide by image size, add edge, saturate.
// ----------------------------------------------------------------------------
module etfi_map
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [9:0]           pixel_x,
    input  logic [9:0]           pixel_y,
    input  etfi_pkg::window_t    win,
    input  logic                 take,
    output logic                 busy,
    output logic                 coord_valid,
    output logic signed [31:0]   coord_x,
    output logic signed [31:0]   coord_y
);

    logic                s1_valid_reg;
    logic signed [43:0]  prod_x_reg;
    logic signed [43:0]  prod_y_reg;
    logic                buf_valid_reg;
    logic signed [31:0]  cx_reg;
    logic signed [31:0]  cy_reg;

    logic signed [32:0]  span_x;
    logic signed [32:0]  span_y;
    logic signed [43:0]  prod_x_next;
    logic signed [43:0]  prod_y_next;
    logic signed [43:0]  off_x;
    logic signed [43:0]  off_y;
    logic signed [31:0]  cx_next;
    logic signed [31:0]  cy_next;

    always_comb
    begin
        span_x      = 33'(win.x_max) - 33'(win.x_min);
        span_y      = 33'(win.y_max) - 33'(win.y_min);
        prod_x_next = 44'(span_x) * $signed({34'd0, pixel_x});
        prod_y_next = 44'(span_y) * $signed({34'd0, pixel_y});
        // truncate toward zero: bias negatives before the shift
        if (prod_x_reg < 0)
            off_x = (prod_x_reg + 44'(etfi_pkg::IMAGE_WIDTH_M1)) >>> etfi_pkg::WIDTH_SHIFT;
        else
            off_x = prod_x_reg >>> etfi_pkg::WIDTH_SHIFT;
        if (prod_y_reg < 0)
            off_y = (prod_y_reg + 44'(etfi_pkg::IMAGE_HEIGHT_M1)) >>> etfi_pkg::HEIGHT_SHIFT;
        else
            off_y = prod_y_reg >>> etfi_pkg::HEIGHT_SHIFT;
        cx_next = etfi_pkg::sat32(66'(win.x_min) + 66'(off_x));
        cy_next = etfi_pkg::sat32(66'(win.y_min) + 66'(off_y));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            buf_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= load;
            if (s1_valid_reg)
                buf_valid_reg <= 1'b1;
            else if (take)
                buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (s1_valid_reg)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

    assign busy        = s1_valid_reg | buf_valid_reg;
    assign coord_valid = buf_valid_reg;
    assign coord_x     = cx_reg;
    assign coord_y     = cy_reg;

endmodule

FILE: design/etfi_cell.sv
// ----------------------------------------------------------------------------
// etfi_cell - one iteration cell of the ring
// Tests the held z for escape and the step limit, else applies one z^2 + c step; registered out.
// ----------------------------------------------------------------------------
module etfi_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  etfi_pkg::step_cfg_t  cfg,
    input  etfi_pkg::slot_t      slot_in,
    output etfi_pkg::slot_t      slot_out
);

    etfi_pkg::slot_t     slot_reg;
    etfi_pkg::slot_t     slot_next;

    logic signed [63:0]  prr;
    logic signed [63:0]  pii;
    logic signed [63:0]  pri;
    logic [63:0]         mag;
    logic                esc;
    logic signed [31:0]  rr;
    logic signed [31:0]  ii;
    logic signed [31:0]  ri2;
    logic signed [31:0]  nr;
    logic signed [31:0]  ni;

    always_comb
    begin
        prr = 64'(slot_in.zr) * 64'(slot_in.zr);
        pii = 64'(slot_in.zi) * 64'(slot_in.zi);
        pri = 64'(slot_in.zr) * 64'(slot_in.zi);
        // squares are non-negative; their sum stays within 2^63
        mag = 64'(prr) + 64'(pii);
        esc = mag > etfi_pkg::ESC_LIMIT;

        rr  = etfi_pkg::sat32(66'(prr >>> etfi_pkg::FRACTION_BITS));
        ii  = etfi_pkg::sat32(66'(pii >>> etfi_pkg::FRACTION_BITS));
        ri2 = etfi_pkg::sat32(66'(pri >>> (etfi_pkg::FRACTION_BITS - 1)));
        nr  = etfi_pkg::sat32(66'(rr) - 66'(ii) + 66'(slot_in.cr));
        ni  = etfi_pkg::sat32(66'(ri2) + 66'(slot_in.ci));
        if (cfg.mode == etfi_pkg::MODE_SHIP)
        begin
            nr = etfi_pkg::abs_sat(nr);
            ni = etfi_pkg::abs_sat(ni);
        end

        slot_next = slot_in;
        if (slot_in.valid && !slot_in.done)
        begin
            if (slot_in.n != 11'd0 && esc)
            begin
                // the last step escaped and is not counted
                slot_next.done = 1'b1;
                slot_next.n    = slot_in.n - 11'd1;
            end
            else if (slot_in.n == cfg.max_iter)
                slot_next.done = 1'b1;
            else
            begin
                slot_next.zr = nr;
                slot_next.zi = ni;
                slot_next.n  = slot_in.n + 11'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else
            slot_reg <= slot_next;
    end

    assign slot_out = slot_reg;

endmodule

FILE: design/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator - Mandelbrot / Julia / burning ship counter
// Maps a pixel to the complex plane and returns its escape-time count.
// ----------------------------------------------------------------------------
// A pixel word is mapped through a product register and a coordinate
// register, then enters a ring of NUM_CELLS iteration cells when the slot
// arriving at the entry is free; it moves one cell per clock and every hop of
// an unfinished pixel is one step of z <- z^2 + c. The mapping front end
// holds one pixel at a time and takes no new word until that pixel has
// entered the ring. Up to NUM_CELLS pixels share the ring, so for long
// counts throughput is set by the chain of dependent steps each pixel needs.
// Results leave in input order through an output register: a finished pixel
// keeps circling until it is the oldest one and the output is free. The
// configuration is written through cfg_write/cfg_index/cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // pixel words in
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [9:0]         pixel_x,
    input  logic [9:0]         pixel_y,
    // count words out
    output logic               out_valid,
    input  logic               out_stall,
    output logic [10:0]        iteration_count
);

    // configuration registers
    logic [1:0]          mode_reg;
    logic [10:0]         max_iter_reg;
    logic signed [31:0]  x_min_reg;
    logic signed [31:0]  x_max_reg;
    logic signed [31:0]  y_min_reg;
    logic signed [31:0]  y_max_reg;
    logic signed [31:0]  julia_re_reg;
    logic signed [31:0]  julia_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= etfi_pkg::MODE_MANDELBROT;
            max_iter_reg <= 11'd64;
            x_min_reg    <= -32'sd536870912;
            x_max_reg    <= 32'sd268435456;
            y_min_reg    <= -32'sd268435456;
            y_max_reg    <= 32'sd268435456;
            julia_re_reg <= 32'sd0;
            julia_im_reg <= 32'sd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                etfi_pkg::REG_FRACTAL_MODE:   mode_reg     <= cfg_data[1:0];
                etfi_pkg::REG_MAX_ITERATIONS: max_iter_reg <= cfg_data[10:0];
                etfi_pkg::REG_X_MIN:          x_min_reg    <= cfg_data;
                etfi_pkg::REG_X_MAX:          x_max_reg    <= cfg_data;
                etfi_pkg::REG_Y_MIN:          y_min_reg    <= cfg_data;
                etfi_pkg::REG_Y_MAX:          y_max_reg    <= cfg_data;
                etfi_pkg::REG_JULIA_RE:       julia_re_reg <= cfg_data;
                etfi_pkg::REG_JULIA_IM:       julia_im_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    etfi_pkg::window_t   win;
    etfi_pkg::step_cfg_t step_cfg;

    assign win.x_min         = x_min_reg;
    assign win.x_max         = x_max_reg;
    assign win.y_min         = y_min_reg;
    assign win.y_max         = y_max_reg;
    assign step_cfg.mode     = mode_reg;
    assign step_cfg.max_iter = max_iter_reg;

    // mapping front end; one pixel word at a time
    logic                map_busy;
    logic                coord_valid;
    logic signed [31:0]  coord_x;
    logic signed [31:0]  coord_y;
    logic                take;
    logic                accept;

    assign in_stall = map_busy;
    assign accept   = in_valid && !map_busy;

    etfi_map u_map
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .win         (win),
        .take        (take),
        .busy        (map_busy),
        .coord_valid (coord_valid),
        .coord_x     (coord_x),
        .coord_y     (coord_y)
    );

    // ring of cells; entry and exit sit between the last cell and the first
    etfi_pkg::slot_t     cell_q [etfi_pkg::NUM_CELLS];
    etfi_pkg::slot_t     ring_in;
    logic [etfi_pkg::TAG_W-1:0] in_seq_reg;
    logic [etfi_pkg::TAG_W-1:0] out_seq_reg;
    logic                out_free;
    logic                emit;
    etfi_pkg::slot_t     tail;

    assign tail     = cell_q[etfi_pkg::NUM_CELLS-1];
    assign out_free = !out_valid || !out_stall;
    // only the oldest pixel in flight may leave
    assign emit     = tail.valid && tail.done && (tail.tag == out_seq_reg) && out_free;

    always_comb
    begin
        ring_in = tail;
        take    = 1'b0;
        if (emit)
            ring_in.valid = 1'b0;
        if (!ring_in.valid && coord_valid)
        begin
            take          = 1'b1;
            ring_in.valid = 1'b1;
            ring_in.done  = 1'b0;
            ring_in.tag   = in_seq_reg;
            ring_in.n     = 11'd0;
            if (mode_reg == etfi_pkg::MODE_JULIA)
            begin
                ring_in.zr = coord_x;
                ring_in.zi = coord_y;
                ring_in.cr = julia_re_reg;
                ring_in.ci = julia_im_reg;
            end
            else
            begin
                ring_in.zr = 32'sd0;
                ring_in.zi = 32'sd0;
                ring_in.cr = coord_x;
                ring_in.ci = coord_y;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < etfi_pkg::NUM_CELLS; gi++)
        begin : g_cell
            etfi_pkg::slot_t cell_d;
            if (gi == 0)
            begin : g_head
                assign cell_d = ring_in;
            end
            else
            begin : g_link
                assign cell_d = cell_q[gi-1];
            end
            etfi_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cfg      (step_cfg),
                .slot_in  (cell_d),
                .slot_out (cell_q[gi])
            );
        end
    endgenerate

    // sequence tags and output register
    logic [10:0]         count_reg;
    logic                out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_seq_reg    <= '0;
            out_seq_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_seq_reg <= in_seq_reg + 1'b1;
            if (emit)
            begin
                out_seq_reg   <= out_seq_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            count_reg <= tail.n;
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = count_reg;

endmodule
